>>> sv/value_noise_fbm_2d_unit_defines.svh
// Assertion macros for the value noise fBm unit.
// Uses clk and arst_n of the module that includes it.
`ifndef VALUE_NOISE_FBM_2D_UNIT_DEFINES_SVH
`define VALUE_NOISE_FBM_2D_UNIT_DEFINES_SVH

// property that must hold at every edge out of reset
`define VNF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define VNF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/vnf_pkg.sv
// Shared constants and types for the value noise fBm unit.
// No dependencies.
package vnf_pkg;

	localparam int OCTAVES   = 4;
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 32;
	localparam int OUT_W     = FRAC_BITS + 2;
	localparam int COORD_W   = IN_W + OCTAVES - 1;
	localparam int ACC_W     = IN_W + OCTAVES;

	// normalization: divide by (2^OCTAVES - 1) * 2^(30 - FRAC_BITS)
	localparam int DIV_ODD = (1 << OCTAVES) - 1;
	localparam int NW      = FRAC_BITS + OCTAVES;
	localparam int KSH     = NW + $clog2(DIV_ODD);
	localparam int RW      = KSH + 1;
	localparam logic [63:0] RECIP    = ((64'd1 << KSH) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);
	localparam logic [63:0] HALF_RND = 64'(DIV_ODD) << (29 - FRAC_BITS);

	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [ACC_W-1:0]   acc;
	} vnf_bus_t;

endpackage

>>> sv/vnf_cell.sv
// One octave cell: lattice hash of four corners, bilinear blend, Horner accumulate.
// Depends on vnf_pkg.
module vnf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  vnf_pkg::vnf_bus_t  bus_i,
	output vnf_pkg::vnf_bus_t  bus_o
);
	import vnf_pkg::*;

	typedef logic [3:0][31:0] lane4_t;

	localparam logic [31:0] MIX_X   = 32'd1619;
	localparam logic [31:0] MIX_Y   = 32'd31337;
	localparam logic [31:0] MIX_C   = 32'd1013;
	localparam logic [31:0] H_A     = 32'd15731;
	localparam logic [31:0] H_B     = 32'd789221;
	localparam logic [31:0] H_C     = 32'd1376312589;
	localparam logic [31:0] LAT_ONE = 32'h4000_0000;

	function automatic logic signed [31:0] lerp_q(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [FRAC_BITS-1:0] t);
		logic signed [32:0]           d;
		logic signed [FRAC_BITS+33:0] p;
		d = 33'(b) - 33'(a);
		p = d * $signed({1'b0, t});
		return a + 32'(p >>> FRAC_BITS);
	endfunction

	vnf_bus_t bus_s1, bus_s2, bus_s3, bus_s4, bus_s5, bus_s6, bus_s7, bus_s8;
	lane4_t   m_s1, m_s2, m_s3, sq_s2, p_s3, q_s4, lat_s5;
	logic signed [31:0] r0_s6, r1_s6, r_s7;

	logic signed [63:0] xe, ye;
	logic [31:0] x0, y0, x1, y1, mix;
	lane4_t cxl, cyl, m_c, sq_c, p_c, q_c, lat_c;
	vnf_bus_t bus_c;

	always_comb begin
		xe = 64'(bus_i.x);
		ye = 64'(bus_i.y);
		x0 = xe[FRAC_BITS +: 32];
		y0 = ye[FRAC_BITS +: 32];
		x1 = x0 + 32'd1;
		y1 = y0 + 32'd1;
		cxl = {x1, x0, x1, x0};
		cyl = {y1, y1, y0, y0};
		for (int l = 0; l < 4; l++) begin
			mix = cxl[l] * MIX_X + cyl[l] * MIX_Y + MIX_C;
			m_c[l]   = mix ^ (mix << 13);
			sq_c[l]  = m_s1[l] * m_s1[l];
			p_c[l]   = sq_s2[l] * H_A + H_B;
			q_c[l]   = m_s3[l] * p_s3[l];
			lat_c[l] = LAT_ONE - ((q_s4[l] + H_C) & 32'h7fff_ffff);
		end
	end

	always_comb begin
		bus_c = bus_s7;
		bus_c.acc = (bus_s7.acc <<< 1) + ACC_W'(r_s7);
		// next octave sees the point at twice the frequency
		bus_c.x = bus_s7.x <<< 1;
		bus_c.y = bus_s7.y <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_s1 <= '0;
			bus_s2 <= '0;
			bus_s3 <= '0;
			bus_s4 <= '0;
			bus_s5 <= '0;
			bus_s6 <= '0;
			bus_s7 <= '0;
			bus_s8 <= '0;
		end else if (adv) begin
			bus_s1 <= bus_i;
			bus_s2 <= bus_s1;
			bus_s3 <= bus_s2;
			bus_s4 <= bus_s3;
			bus_s5 <= bus_s4;
			bus_s6 <= bus_s5;
			bus_s7 <= bus_s6;
			bus_s8 <= bus_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1   <= m_c;
			m_s2   <= m_s1;
			sq_s2  <= sq_c;
			m_s3   <= m_s2;
			p_s3   <= p_c;
			q_s4   <= q_c;
			lat_s5 <= lat_c;
			r0_s6  <= lerp_q($signed(lat_s5[0]), $signed(lat_s5[1]), bus_s5.x[FRAC_BITS-1:0]);
			r1_s6  <= lerp_q($signed(lat_s5[2]), $signed(lat_s5[3]), bus_s5.x[FRAC_BITS-1:0]);
			r_s7   <= lerp_q(r0_s6, r1_s6, bus_s6.y[FRAC_BITS-1:0]);
		end
	end

	assign bus_o = bus_s8;

endmodule

>>> sv/vnf_norm.sv
// Normalizer: scales the weighted octave sum to Q1.16, rounding half away from zero.
// Depends on vnf_pkg.
module vnf_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              sum_valid,
	input  logic signed [vnf_pkg::ACC_W-1:0]  sum,
	output logic                              fin_valid,
	output logic signed [vnf_pkg::OUT_W-1:0]  fin_value
);
	import vnf_pkg::*;

	logic              valid_s1, valid_s2, neg_s1;
	logic [NW-1:0]     n_s1;
	logic signed [OUT_W-1:0] value_s2;
	logic [ACC_W-1:0]  mag, rnd;
	logic [NW+RW-1:0]  prod;
	logic [OUT_W-1:0]  quo;

	always_comb begin
		mag  = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
		rnd  = mag + ACC_W'(HALF_RND);
		// multiply by reciprocal of the odd divisor
		prod = (NW+RW)'(n_s1) * (NW+RW)'(RECIP[RW-1:0]);
		quo  = OUT_W'(prod >> KSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sum_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= sum[ACC_W-1];
			n_s1     <= NW'(rnd >> (30 - FRAC_BITS));
			value_s2 <= neg_s1 ? -$signed(quo) : $signed(quo);
		end
	end

	assign fin_valid = valid_s2;
	assign fin_value = value_s2;

endmodule

>>> sv/value_noise_fbm_2d_unit.sv
// Top level of the 2D value noise fBm unit: octave cell chain, normalizer, output skid.
// Depends on vnf_pkg, vnf_cell, vnf_norm and value_noise_fbm_2d_unit_defines.svh.
//
// Usage:
//   Input channel: coord_valid/coord_ready carry coord_x, coord_y (signed Q16.16).
//   Output channel: noise_valid/noise_ready carry noise_value (signed Q1.16).
//   Each point walks a chain of four identical octave cells, eight stages each,
//   then a two-stage normalizer and an output register.
//   Throughput is one point per cycle while the skid register is empty;
//   every stage holds an independent point.
//   The pipeline shares one advance enable, driven by the output skid stage:
//   while a result waits, one more finished result parks in the skid register,
//   and only when that is full does the pipeline hold and coord_ready drop.
//   Reset clears all valid flags; no stored data must be cleared, so the
//   block takes a transaction in the first cycle after reset.
//   A stalled receiver sees noise_value held until it takes the transaction.
`include "value_noise_fbm_2d_unit_defines.svh"

module value_noise_fbm_2d_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 coord_valid,
	output logic                                 coord_ready,
	input  logic signed [vnf_pkg::IN_W-1:0]      coord_x,
	input  logic signed [vnf_pkg::IN_W-1:0]      coord_y,
	output logic                                 noise_valid,
	input  logic                                 noise_ready,
	output logic signed [vnf_pkg::OUT_W-1:0]     noise_value
);
	import vnf_pkg::*;

	vnf_bus_t chain [0:OCTAVES];
	logic     adv, fin_valid;
	logic signed [OUT_W-1:0] fin_value, res_q, skid_q;
	logic     res_valid_q, skid_valid_q;

	assign adv         = !skid_valid_q;
	assign coord_ready = adv;

	assign chain[0] = '{valid: coord_valid && coord_ready, x: COORD_W'(coord_x),
		y: COORD_W'(coord_y), acc: '0};

	for (genvar i = 0; i < OCTAVES; i++) begin : g_cell
		vnf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.bus_i  (chain[i]),
			.bus_o  (chain[i+1])
		);
	end

	vnf_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.sum_valid (chain[OCTAVES].valid),
		.sum       (chain[OCTAVES].acc),
		.fin_valid (fin_valid),
		.fin_value (fin_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			res_q        <= '0;
			skid_q       <= '0;
		end else if (res_valid_q && !noise_ready) begin
			// hold the output, park one more result
			if (adv && fin_valid) begin
				skid_valid_q <= 1'b1;
				skid_q       <= fin_value;
			end
		end else if (skid_valid_q) begin
			res_valid_q  <= 1'b1;
			res_q        <= skid_q;
			skid_valid_q <= 1'b0;
		end else begin
			res_valid_q <= fin_valid;
			res_q       <= fin_value;
		end
	end

	assign noise_valid = res_valid_q;
	assign noise_value = res_q;

	`VNF_ASSERT_ALWAYS(a_skid_implies_res, !skid_valid_q || res_valid_q, "skid full with empty output")
	`VNF_ASSERT_NEXT(a_skid_holds, skid_valid_q && !noise_ready, skid_valid_q, "skid lost while stalled")
	`VNF_ASSERT_NEXT(a_drain, res_valid_q && noise_ready && !skid_valid_q && !fin_valid, !res_valid_q, "result repeated")

endmodule

>>> tb/tb.sv
// Testbench for value_noise_fbm_2d_unit: directed table then random points, each
// result checked against a fixed-point fBm value noise predictor. Depends on vnf_pkg.
module tb;
	import vnf_pkg::*;

	logic clk;
	logic arst_n;
	logic coord_valid;
	logic coord_ready;
	logic signed [IN_W-1:0] coord_x;
	logic signed [IN_W-1:0] coord_y;
	logic noise_valid;
	logic noise_ready;
	logic signed [OUT_W-1:0] noise_value;

	value_noise_fbm_2d_unit dut (
		.clk(clk), .arst_n(arst_n),
		.coord_valid(coord_valid), .coord_ready(coord_ready),
		.coord_x(coord_x), .coord_y(coord_y),
		.noise_valid(noise_valid), .noise_ready(noise_ready),
		.noise_value(noise_value)
	);

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		bit has_val;
		logic [OUT_W-1:0] val;
	} point_row_t;

	localparam int NUM_ROWS = 14;
	localparam int NUM_RAND = 1300;

	logic [OUT_W-1:0] noise_q[$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;

	function automatic longint floor_div(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint lattice_val(logic [31:0] cx, logic [31:0] cy);
		logic [31:0] m;
		logic [31:0] h;
		m = cx * 32'd1619 + cy * 32'd31337 + 32'd1013;
		m = (m << 13) ^ m;
		h = (m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
		return longint'(64'h40000000) - longint'({32'd0, h});
	endfunction

	function automatic longint lerp_frac(longint a, longint b, longint t);
		return a + floor_div((b - a) * t, FRAC_BITS);
	endfunction

	function automatic longint octave_val(longint x, longint y);
		longint tx, ty, r0, r1;
		logic [31:0] x0, y0;
		tx = x & ((64'd1 << FRAC_BITS) - 1);
		ty = y & ((64'd1 << FRAC_BITS) - 1);
		x0 = 32'(floor_div(x, FRAC_BITS));
		y0 = 32'(floor_div(y, FRAC_BITS));
		r0 = lerp_frac(lattice_val(x0, y0), lattice_val(x0 + 32'd1, y0), tx);
		r1 = lerp_frac(lattice_val(x0, y0 + 32'd1), lattice_val(x0 + 32'd1, y0 + 32'd1), tx);
		return lerp_frac(r0, r1, ty);
	endfunction

	function automatic logic [OUT_W-1:0] fbm_noise(logic [31:0] px, logic [31:0] py);
		longint x, y, sum, dv, mag, q;
		x = longint'(signed'(px));
		y = longint'(signed'(py));
		sum = 0;
		for (int i = 0; i < OCTAVES; i++)
			sum += octave_val(x <<< i, y <<< i) <<< (OCTAVES - 1 - i);
		dv = ((64'd1 << OCTAVES) - 1) << (30 - FRAC_BITS);
		mag = sum < 0 ? -sum : sum;
		q = (mag + dv / 2) / dv;
		return OUT_W'(sum < 0 ? -q : q);
	endfunction

	point_row_t rows[NUM_ROWS];

	initial begin
		// origin hashes to corner value at (0,0) only; extremes and sign boundaries follow
		rows[0]  = '{32'h0000_0000, 32'h0000_0000, 0, '0};
		rows[1]  = '{32'h7fff_ffff, 32'h7fff_ffff, 0, '0};
		rows[2]  = '{32'h8000_0000, 32'h8000_0000, 0, '0};
		rows[3]  = '{32'h7fff_ffff, 32'h8000_0000, 0, '0};
		rows[4]  = '{32'h8000_0000, 32'h7fff_ffff, 0, '0};
		rows[5]  = '{32'hffff_ffff, 32'hffff_ffff, 0, '0};
		rows[6]  = '{32'h0001_0000, 32'h0000_0000, 0, '0};
		rows[7]  = '{32'hffff_0000, 32'h0000_8000, 0, '0};
		rows[8]  = '{32'h0000_8000, 32'hffff_8000, 0, '0};
		rows[9]  = '{32'h5555_5555, 32'haaaa_aaaa, 0, '0};
		rows[10] = '{32'haaaa_aaaa, 32'h5555_5555, 0, '0};
		rows[11] = '{32'h4000_0000, 32'hc000_0000, 0, '0};
		rows[12] = '{32'h0000_ffff, 32'h0000_0001, 0, '0};
		rows[13] = '{32'hfffe_0001, 32'h0123_4567, 0, '0};
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_point(logic [31:0] px, logic [31:0] py);
		// drop valid only while idling, so back-to-back transactions keep it high
		while ($urandom_range(99) < send_idle_pct) begin
			coord_valid <= 1'b0;
			@(negedge clk);
		end
		coord_valid <= 1'b1;
		coord_x <= px;
		coord_y <= py;
		@(posedge clk);
		while (!coord_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(int s_pct, int r_pct, int count);
		logic [31:0] rx, ry;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(3))
				0: begin
					rx = $urandom_range(32'h0008_0000) - 32'h0004_0000;
					ry = $urandom_range(32'h0008_0000) - 32'h0004_0000;
				end
				1: begin
					rx = {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
					ry = {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom)};
				end
				default: begin
					rx = $urandom;
					ry = $urandom;
				end
			endcase
			noise_q.push_back(fbm_noise(rx, ry));
			send_point(rx, ry);
		end
	endtask

	always @(negedge clk) begin
		noise_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && noise_valid && noise_ready) begin
			if (noise_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: noise_value=%h", noise_value);
			end else begin
				if (noise_value !== noise_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("noise_value mismatch: exp %h got %h", noise_q[0], noise_value);
				end
				void'(noise_q.pop_front());
			end
		end
	end

	initial begin
		int wait_cnt;
		mismatches = 0;
		arst_n = 1'b0;
		coord_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < NUM_ROWS; r++) begin
			if (rows[r].has_val)
				noise_q.push_back(rows[r].val);
			else
				noise_q.push_back(fbm_noise(rows[r].x, rows[r].y));
			send_point(rows[r].x, rows[r].y);
		end

		run_phase(33, 64, NUM_RAND / 3);
		run_phase(64, 33, NUM_RAND / 3);
		run_phase(0, 0, NUM_RAND - 2 * (NUM_RAND / 3));
		coord_valid <= 1'b0;

		// drain, then allow the pipeline depth for any stray transaction
		wait_cnt = 0;
		while (noise_q.size() != 0 && wait_cnt < 100_000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (50) @(posedge clk);
		if (mismatches == 0 && noise_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+sv
sv/vnf_pkg.sv
sv/vnf_cell.sv
sv/vnf_norm.sv
sv/value_noise_fbm_2d_unit.sv
tb/tb.sv
